>>> rtl/slat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slat_pkg
// Shared constants and types of the set-associative LRU hit tracker.
// ----------------------------------------------------------------------------
package slat_pkg;

    // Cache geometry
    localparam int NUM_SETS    = 32;
    localparam int NUM_WAYS    = 4;
    localparam int LINE_BYTES  = 64;
    localparam int ADDR_BITS   = 48;

    // Derived widths
    localparam int OFFSET_BITS = $clog2(LINE_BYTES);
    localparam int SET_IDX     = $clog2(NUM_SETS);
    localparam int SET_BITS    = (SET_IDX > 0) ? SET_IDX : 1;
    localparam int WAY_BITS    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LINE_BITS   = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_BITS    = LINE_BITS - SET_IDX;
    localparam int ROW_BITS    = NUM_WAYS * TAG_BITS;
    localparam int CNT_BITS    = 32;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // One classified lookup request
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [SET_BITS-1:0] set_idx;
    } t_req;

endpackage

>>> rtl/set_assoc_lru_hit_tracker_top.sv
`timescale 1ns / 1ps
// With the engine idle, an accepted request passes the request queue, the registered
// tag RAM read and the result register before its result strobes. The lookup engine
// takes one request at a time through its read-then-resolve sequence on the tag RAM.
// A 2-entry request queue absorbs bursts; busy rises when it is full.
// Synchronous active-low reset clears valid bits, LRU order and miss count.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// set_assoc_lru_hit_tracker_top
// Tag-only 4-way set-associative cache tracker with true LRU replacement.
// ----------------------------------------------------------------------------
module set_assoc_lru_hit_tracker_top
    import slat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ADDR_BITS-1:0] i_byte_address,
    output logic                 o_done,
    output logic                 o_hit,
    output logic [CNT_BITS-1:0]  o_miss_total
);

    logic req_valid;
    logic req_pop;
    t_req req;

    // Accept and classify
    slat_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_byte_address (i_byte_address),
        .i_pop          (req_pop),
        .o_req_valid    (req_valid),
        .o_req          (req)
    );

    // Look up and update
    slat_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req        (req),
        .o_pop        (req_pop),
        .o_done       (o_done),
        .o_hit        (o_hit),
        .o_miss_total (o_miss_total)
    );

endmodule

>>> rtl/slat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/slat_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slat_front
// Accepts byte addresses, splits them into set index and tag, and queues
// the resulting requests for the lookup engine.
// ----------------------------------------------------------------------------
module slat_front
    import slat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ADDR_BITS-1:0] i_byte_address,
    input  logic                 i_pop,
    output logic                 o_req_valid,
    output t_req                 o_req
);

    t_req                 r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count, n_count;

    logic [LINE_BITS-1:0] line_num;
    t_req                 new_req;
    logic                 push;
    logic                 pop;

    // Classify the address into set and tag
    assign line_num         = i_byte_address[ADDR_BITS-1:OFFSET_BITS];
    assign new_req.set_idx  = SET_BITS'(line_num % NUM_SETS);
    assign new_req.tag      = TAG_BITS'(line_num / NUM_SETS);

    assign busy        = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign push        = start && !busy;
    assign pop         = i_pop && (r_count != '0);
    assign o_req_valid = (r_count != '0);
    assign o_req       = r_queue[r_rd_ptr];

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_req;
        end
    end

endmodule

>>> rtl/slat_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slat_back
// Lookup engine: reads the set's tag row, detects a hit, picks the fill or
// victim way, updates tags, valid bits and LRU order, and reports the result.
// ----------------------------------------------------------------------------
module slat_back
    import slat_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  t_req                i_req,
    output logic                o_pop,
    output logic                o_done,
    output logic                o_hit,
    output logic [CNT_BITS-1:0] o_miss_total
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    typedef logic [NUM_WAYS-1:0][WAY_BITS-1:0] t_order;

    logic                r_state, n_state;
    logic [SET_BITS-1:0] r_set;
    logic [TAG_BITS-1:0] r_tag;
    logic [NUM_WAYS-1:0] r_valid [NUM_SETS];
    t_order              r_lru   [NUM_SETS];
    logic [CNT_BITS-1:0] r_miss_cnt, n_miss_cnt;
    logic                r_done, n_done;
    logic                r_hit;

    logic [ROW_BITS-1:0] row_rd;
    logic [ROW_BITS-1:0] row_wr;
    logic                ram_we;
    logic [NUM_WAYS-1:0] set_valid;
    t_order              set_order;
    t_order              new_order;
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                empty_found;
    logic [WAY_BITS-1:0] empty_way;
    logic [WAY_BITS-1:0] touch_way;
    logic [WAY_BITS-1:0] mru_pos;
    logic                in_look;

    // Tag rows, one per set
    slat_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_set),
        .i_wdata (row_wr),
        .i_raddr (i_req.set_idx),
        .o_rdata (row_rd)
    );

    assign in_look   = (r_state == ST_LOOK);
    assign o_pop     = (r_state == ST_IDLE) && i_req_valid;
    assign set_valid = r_valid[r_set];
    assign set_order = r_lru[r_set];

    // Compare tags; lowest matching way wins
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (set_valid[w] && (row_rd[w*TAG_BITS +: TAG_BITS] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
    end

    // Find the lowest empty way
    always_comb begin
        empty_found = 1'b0;
        empty_way   = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!set_valid[w]) begin
                empty_found = 1'b1;
                empty_way   = WAY_BITS'(w);
            end
        end
    end

    assign touch_way = hit         ? hit_way   :
                       empty_found ? empty_way :
                                     set_order[NUM_WAYS-1];

    // Move the touched way to the front of the LRU order
    always_comb begin
        mru_pos = WAY_BITS'(NUM_WAYS - 1);
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (set_order[i] == touch_way) begin
                mru_pos = WAY_BITS'(i);
            end
        end
        new_order    = set_order;
        new_order[0] = touch_way;
        for (int i = 1; i < NUM_WAYS; i++) begin
            if (WAY_BITS'(i) <= mru_pos) begin
                new_order[i] = set_order[i-1];
            end
        end
    end

    // Replace the victim's tag on a miss
    always_comb begin
        row_wr = row_rd;
        row_wr[touch_way*TAG_BITS +: TAG_BITS] = r_tag;
    end

    assign ram_we = in_look && !hit;

    // Sequence one request at a time: read, then resolve
    always_comb begin
        n_state    = r_state;
        n_miss_cnt = r_miss_cnt;
        n_done     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (!hit && (r_miss_cnt != '1)) begin
                    n_miss_cnt = r_miss_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_miss_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_miss_cnt <= n_miss_cnt;
            r_done     <= n_done;
        end
    end

    // Update valid bits and LRU order of the resolved set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    r_lru[s][w] <= WAY_BITS'(w);
                end
            end
        end else if (in_look) begin
            r_valid[r_set][touch_way] <= 1'b1;
            r_lru[r_set]              <= new_order;
        end
    end

    // Hold the popped request and the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_set <= i_req.set_idx;
            r_tag <= i_req.tag;
        end
        if (in_look) begin
            r_hit <= hit;
        end
    end

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_miss_total = r_miss_cnt;

endmodule

>>> rtl/slat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slat_checker
// Port-level checks of the hit tracker: result spacing, outstanding
// transactions and miss count progression.
// ----------------------------------------------------------------------------
module slat_checker
    import slat_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic                 o_hit,
    input logic [CNT_BITS-1:0]  o_miss_total
);

    logic [2:0]          r_pend;
    logic [CNT_BITS-1:0] r_last_total;
    logic                accepted;

    assign accepted = start && !busy;

    // Track outstanding transactions and the last reported total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= '0;
            r_last_total <= '0;
        end else begin
            r_pend <= r_pend + {2'b00, accepted} - {2'b00, o_done};
            if (o_done) begin
                r_last_total <= o_miss_total;
            end
        end
    end

    // Results are never back to back
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results on consecutive cycles");

    // No result without an accepted transaction
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_pend != '0))
        else $error("result without pending transaction");

    // A hit leaves the miss total unchanged
    a_hit_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_miss_total == r_last_total))
        else $error("miss total changed on hit");

    // A miss adds one, or holds at saturation
    a_miss_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |->
            ((o_miss_total == r_last_total + 1'b1) ||
             ((r_last_total == '1) && (o_miss_total == '1))))
        else $error("miss total did not advance on miss");

    // An accepted transaction is counted as pending after its acceptance
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accepted |=> (r_pend != '0))
        else $error("accepted transaction not tracked");

endmodule

bind set_assoc_lru_hit_tracker_top slat_checker u_slat_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 4-way set-associative LRU hit tracker against a cycle-free
// model of its tag store. Directed lookups cover the address extremes,
// hits within one line, filling of empty ways and LRU eviction. Random
// traffic then runs over a few hot sets with a small pool of tags, mixed with
// fully random addresses, under several sender idle rates. Every result is
// compared with the oldest predicted lookup.
// ----------------------------------------------------------------------------
module testbench;
    import slat_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct {
        logic                hit;
        logic [CNT_BITS-1:0] miss_total;
    } t_lookup_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [ADDR_BITS-1:0] i_byte_address;
    logic                 o_done;
    logic                 o_hit;
    logic [CNT_BITS-1:0]  o_miss_total;

    // Tag store copy used for prediction
    logic [NUM_WAYS-1:0] set_valid [NUM_SETS];
    logic [TAG_BITS-1:0] set_tags  [NUM_SETS][NUM_WAYS];
    logic [WAY_BITS-1:0] lru_rank  [NUM_SETS][NUM_WAYS];
    logic [CNT_BITS-1:0] miss_tally;

    t_lookup_result pending_lookups[$];
    t_lookup_result oldest_lookup;
    int             idle_pct;
    int             fail_count;
    int             quiet_cycles;

    set_assoc_lru_hit_tracker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_byte_address (i_byte_address),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_miss_total   (o_miss_total)
    );

    // Generate the 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Restore the model to its post-reset state
    function automatic void clear_tag_model();
        for (int s = 0; s < NUM_SETS; s++) begin
            set_valid[s] = '0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                set_tags[s][w] = '0;
                lru_rank[s][w] = WAY_BITS'(w);
            end
        end
        miss_tally = '0;
    endfunction

    // Move a way to the most recently used slot of its set
    function automatic void promote_way(input logic [SET_BITS-1:0] set_sel, input int way);
        int pos;
        pos = NUM_WAYS - 1;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (lru_rank[set_sel][i] == WAY_BITS'(way)) pos = i;
        end
        for (int i = pos; i > 0; i--) lru_rank[set_sel][i] = lru_rank[set_sel][i-1];
        lru_rank[set_sel][0] = WAY_BITS'(way);
    endfunction

    // Look up one address, update the model and return the expected result
    function automatic t_lookup_result predict_lookup(input logic [ADDR_BITS-1:0] addr);
        logic [SET_BITS-1:0] set_sel;
        logic [TAG_BITS-1:0] tag_val;
        int                  hit_way;
        int                  victim;
        t_lookup_result      res;
        set_sel = addr[OFFSET_BITS +: SET_BITS];
        tag_val = addr[OFFSET_BITS + SET_IDX +: TAG_BITS];
        hit_way = -1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (hit_way < 0 && set_valid[set_sel][w] && set_tags[set_sel][w] == tag_val)
                hit_way = w;
        end
        if (hit_way >= 0) begin
            promote_way(set_sel, hit_way);
        end else begin
            if (miss_tally != '1) miss_tally = miss_tally + 1'b1;
            // Prefer the lowest empty way, else evict the LRU way
            victim = -1;
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (!set_valid[set_sel][w]) victim = w;
            end
            if (victim < 0) victim = int'(lru_rank[set_sel][NUM_WAYS-1]);
            set_tags[set_sel][victim]  = tag_val;
            set_valid[set_sel][victim] = 1'b1;
            promote_way(set_sel, victim);
        end
        res.hit        = (hit_way >= 0);
        res.miss_total = miss_tally;
        return res;
    endfunction

    function automatic logic [ADDR_BITS-1:0] make_addr(input logic [TAG_BITS-1:0] tag_val,
                                                        input logic [SET_BITS-1:0] set_sel,
                                                        input logic [OFFSET_BITS-1:0] offs);
        return {tag_val, set_sel[SET_IDX-1:0], offs};
    endfunction

    // Send one lookup transaction, idling first at the current rate
    task automatic send_access(input logic [ADDR_BITS-1:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_byte_address <= addr;
        do @(posedge i_clk); while (busy);
        pending_lookups.push_back(predict_lookup(addr));
    endtask

    // Hold off until every predicted result has come back
    task automatic wait_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_lookups.size() != 0);
    endtask

    task automatic apply_reset();
        start          <= 1'b0;
        i_byte_address <= '0;
        i_rst_n        <= 1'b0;
        clear_tag_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Lowest and highest addresses, then repeat them as hits
    task automatic test_address_extremes();
        idle_pct = 0;
        send_access('0);
        send_access('1);
        send_access('0);
        send_access(make_addr('1, '1, '0));
        send_access(make_addr('0, '0, '1));
        wait_drain();
    endtask

    // Hit on other byte offsets of a freshly filled line
    task automatic test_line_offsets();
        logic [TAG_BITS-1:0] tag_val;
        tag_val = TAG_BITS'({$urandom, $urandom});
        idle_pct = 30;
        send_access(make_addr(tag_val, 5'd3, 6'd17));
        send_access(make_addr(tag_val, 5'd3, 6'd0));
        send_access(make_addr(tag_val, 5'd3, 6'd63));
        send_access(make_addr(tag_val, 5'd3, 6'd32));
        wait_drain();
    endtask

    // Fill all ways of a set, reorder by a hit, then force LRU evictions
    task automatic test_fill_and_evict();
        logic [TAG_BITS-1:0] tag_a;
        tag_a = TAG_BITS'({$urandom, $urandom});
        idle_pct = 0;
        send_access(make_addr(tag_a, 5'd7, 6'd0));
        send_access(make_addr(tag_a ^ 1, 5'd7, 6'd4));
        send_access(make_addr(tag_a ^ 2, 5'd7, 6'd8));
        send_access(make_addr(tag_a ^ (TAG_BITS'(1) << (TAG_BITS - 1)), 5'd7, 6'd12));
        send_access(make_addr(tag_a, 5'd7, 6'd1));
        send_access(make_addr(tag_a ^ 3, 5'd7, 6'd2));
        send_access(make_addr(tag_a ^ 1, 5'd7, 6'd3));
        send_access(make_addr(tag_a, 5'd7, 6'd5));
        send_access(make_addr(tag_a ^ 2, 5'd7, 6'd6));
        send_access(make_addr(tag_a ^ 3, 5'd7, 6'd7));
        wait_drain();
    endtask

    // Hot sets with a small tag pool, mixed with fully random addresses
    task automatic test_random_traffic(input int count, input int idle);
        logic [TAG_BITS-1:0] tag_pool [6];
        logic [SET_BITS-1:0] hot_base;
        logic [63:0]         rnd;
        idle_pct = idle;
        hot_base = SET_BITS'($urandom);
        for (int i = 0; i < 6; i++) tag_pool[i] = TAG_BITS'({$urandom, $urandom});
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        repeat (count) begin
            rnd = {$urandom, $urandom};
            if ($urandom_range(99) < 80)
                send_access(make_addr(tag_pool[$urandom_range(5)],
                                      SET_BITS'(hot_base + $urandom_range(3)),
                                      rnd[OFFSET_BITS-1:0]));
            else
                send_access(rnd[ADDR_BITS-1:0]);
        end
        wait_drain();
    endtask

    // Compare each result with the oldest prediction; watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_lookups.size() == 0) begin
                    $error("unexpected result: hit=%0d miss_total=%0d", o_hit, o_miss_total);
                    fail_count++;
                end else begin
                    oldest_lookup = pending_lookups.pop_front();
                    if (o_hit !== oldest_lookup.hit) begin
                        $error("hit mismatch: expected %0d, actual %0d",
                               oldest_lookup.hit, o_hit);
                        fail_count++;
                    end
                    if (o_miss_total !== oldest_lookup.miss_total) begin
                        $error("miss_total mismatch: expected %0d, actual %0d",
                               oldest_lookup.miss_total, o_miss_total);
                        fail_count++;
                    end
                end
            end
            if ((start && !busy) || o_done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        fail_count   = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        apply_reset();
        test_address_extremes();
        test_line_offsets();
        test_fill_and_evict();
        test_random_traffic(150, 0);
        test_random_traffic(120, 73);
        test_random_traffic(120, 13);
        test_random_traffic(110, 0);
        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_lookups.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/slat_pkg.sv
rtl/slat_ram.sv
rtl/slat_front.sv
rtl/slat_back.sv
rtl/set_assoc_lru_hit_tracker_top.sv
rtl/slat_checker.sv
tb/sv/testbench.sv
